>>> rtl/cfp_pkg.sv
package cfp_pkg;

  // Sync byte after reset.
  localparam logic [7:0] StartByteReset = 8'hF5;

  // Frame type codes that map to commands.
  localparam logic [7:0] TypeArm      = 8'hF1;
  localparam logic [7:0] TypeRecStart = 8'hF2;
  localparam logic [7:0] TypeRecStop  = 8'hF3;
  localparam logic [7:0] TypeDownload = 8'hF4;

  // Header bytes following the sync byte.
  localparam logic [1:0] HdrType   = 2'd0;
  localparam logic [1:0] HdrLength = 2'd1;
  localparam logic [1:0] HdrSum    = 2'd2;

  localparam int unsigned ResultWidth = 21;
  localparam int unsigned TdataWidth  = 24;

  typedef enum logic [1:0] {
    PhIdle,
    PhHeader,
    PhPayload
  } phase_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StUnknown = 3'd1,
    StIgnored = 3'd2,
    StHdrBad  = 3'd3,
    StPayBad  = 3'd4,
    StTooLong = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CmdArm      = 2'd0,
    CmdRecStart = 2'd1,
    CmdRecStop  = 2'd2,
    CmdDownload = 2'd3
  } command_e;

  // Declared from the top bit down, so status sits in the lowest bits.
  typedef struct packed {
    logic [7:0] payload_length;
    logic [7:0] frame_type;
    command_e   command;
    status_e    status;
  } result_t;

endpackage

>>> rtl/cfp_parser.sv
module cfp_parser #(
  parameter int unsigned MaxPayload = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             res_ready_i,
  output logic             res_push_o,
  output cfp_pkg::result_t res_o
);

  localparam int unsigned IdxWidth = $clog2(MaxPayload + 1);
  localparam logic [8:0]  MaxLen   = 9'(MaxPayload);

  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic [7:0]            start_byte_q;
  cfp_pkg::phase_e       phase_q, phase_d;
  logic [1:0]            hdr_idx_q, hdr_idx_d;
  logic [7:0]            type_q, type_d;
  logic [7:0]            length_q, length_d;
  logic [IdxWidth-1:0]   pay_idx_q, pay_idx_d;
  logic [7:0]            pay_sum_q, pay_sum_d;
  logic                  step;
  logic [7:0]            hdr_sum;
  cfp_pkg::status_e      status;
  cfp_pkg::command_e     command;
  logic                  finish;

  // The held byte is consumed whenever the result queue has room.
  assign step       = in_valid_q && res_ready_i;
  assign in_ready_o = !in_valid_q || res_ready_i;
  assign hdr_sum    = start_byte_q + type_q + length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= cfp_pkg::StartByteReset;
    end else if (cfg_we_i) begin
      start_byte_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cfp_pkg::PhIdle;
      hdr_idx_q <= cfp_pkg::HdrType;
      type_q    <= '0;
      length_q  <= '0;
      pay_idx_q <= '0;
      pay_sum_q <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      type_q    <= type_d;
      length_q  <= length_d;
      pay_idx_q <= pay_idx_d;
      pay_sum_q <= pay_sum_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    type_d    = type_q;
    length_d  = length_q;
    pay_idx_d = pay_idx_q;
    pay_sum_d = pay_sum_q;
    status    = cfp_pkg::StOk;
    command   = cfp_pkg::CmdArm;
    finish    = 1'b0;
    if (step) begin
      if (phase_q != cfp_pkg::PhPayload && in_byte_q == start_byte_q) begin
        phase_d   = cfp_pkg::PhHeader;
        hdr_idx_d = cfp_pkg::HdrType;
      end else begin
        case (phase_q)
          cfp_pkg::PhHeader: begin
            case (hdr_idx_q)
              cfp_pkg::HdrType: begin
                type_d    = in_byte_q;
                hdr_idx_d = cfp_pkg::HdrLength;
              end
              cfp_pkg::HdrLength: begin
                length_d  = in_byte_q;
                hdr_idx_d = cfp_pkg::HdrSum;
              end
              default: begin
                if (in_byte_q != hdr_sum) begin
                  finish = 1'b1;
                  status = cfp_pkg::StHdrBad;
                end else if (length_q == 8'd0) begin
                  finish = 1'b1;
                  if (type_q inside {[cfp_pkg::TypeArm:cfp_pkg::TypeDownload]}) begin
                    command = cfp_pkg::command_e'(2'(type_q - cfp_pkg::TypeArm));
                  end else begin
                    status = cfp_pkg::StUnknown;
                  end
                end else if ({1'b0, length_q} > MaxLen) begin
                  finish = 1'b1;
                  status = cfp_pkg::StTooLong;
                end else begin
                  phase_d   = cfp_pkg::PhPayload;
                  hdr_idx_d = cfp_pkg::HdrType;
                  pay_idx_d = '0;
                  pay_sum_d = '0;
                end
              end
            endcase
          end
          cfp_pkg::PhPayload: begin
            if (9'(pay_idx_q) < {1'b0, length_q}) begin
              pay_sum_d = pay_sum_q + in_byte_q;
              pay_idx_d = pay_idx_q + 1'b1;
            end else begin
              finish = 1'b1;
              if (in_byte_q != pay_sum_q) begin
                status = cfp_pkg::StPayBad;
              end else if (type_q == cfp_pkg::TypeArm) begin
                command = cfp_pkg::CmdArm;
              end else if (type_q == cfp_pkg::TypeRecStart) begin
                command = cfp_pkg::CmdRecStart;
              end else begin
                status = cfp_pkg::StIgnored;
              end
            end
          end
          default: begin
            phase_d = cfp_pkg::PhIdle;
          end
        endcase
      end
      if (finish) begin
        phase_d   = cfp_pkg::PhIdle;
        hdr_idx_d = cfp_pkg::HdrType;
      end
    end
  end

  assign res_push_o           = finish;
  assign res_o.status         = status;
  assign res_o.command        = command;
  assign res_o.frame_type     = type_q;
  assign res_o.payload_length = length_q;

  a_push_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> step)
    else $error("result pushed without a consumed byte");

  a_push_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> phase_q == cfp_pkg::PhIdle)
    else $error("parser not idle after a frame end");

  a_payload_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cfp_pkg::PhPayload |-> 9'(pay_idx_q) <= {1'b0, length_q})
    else $error("payload counter beyond frame length");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_ready_i |=> $stable(phase_q) && $stable(pay_sum_q))
    else $error("parser state moved while result queue was full");

endmodule

>>> rtl/cfp_out_fifo.sv
module cfp_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cfp_pkg::result_t data_i,
  output logic             not_full_o,
  output logic             valid_o,
  input  logic             ready_i,
  output cfp_pkg::result_t data_o
);

  cfp_pkg::result_t entry_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = count_q != 2'd0;
  assign not_full_o = count_q != 2'd2;
  assign data_o     = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 |-> !push_i)
    else $error("push into a full result queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

>>> rtl/command_frame_parser.sv
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata[7:0] rx_byte
// m_axis    out  tdata status[2:0] command[4:3] frame_type[12:5]
//                payload_length[20:13], zeros above
// cfg       in   start_byte, written when cfg_we_i is high
//
// One byte per cycle. A byte sits in the input register for the cycle after
// its transfer and is parsed there; its result, if any, is on m_axis from the
// following cycle. A two-entry result queue keeps the input flowing while
// m_axis stalls; once it is full the held byte waits and s_axis_tready drops.
// Reset clears the frame state and loads the start byte with 0xF5.
module command_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status, command, frame_type, payload_length, zero padding
  output logic [23:0] m_axis_tdata_o
);

  logic             res_ready;
  logic             res_push;
  cfp_pkg::result_t res;
  cfp_pkg::result_t out_res;

  cfp_parser #(
    .MaxPayload(MAX_PAYLOAD)
  ) u_parser (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .res_ready_i(res_ready),
    .res_push_o (res_push),
    .res_o      (res)
  );

  cfp_out_fifo u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i    (res_push),
    .data_i    (res),
    .not_full_o(res_ready),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .data_o    (out_res)
  );

  assign m_axis_tdata_o = {(cfp_pkg::TdataWidth - cfp_pkg::ResultWidth)'(0), out_res};

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MaxPayload = 16;
  localparam int unsigned QuietLimit = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;

  command_frame_parser #(
    .MAX_PAYLOAD(MaxPayload)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  // Bytes waiting to be sent and results the parser still owes us.
  logic [7:0]       pending_bytes[$];
  cfp_pkg::result_t expected_results[$];
  int unsigned      bytes_queued = 0;
  logic [7:0]       stim_start = cfp_pkg::StartByteReset;
  int unsigned      fail_count = 0;

  // Our own copy of the parser state.
  cfp_pkg::phase_e prs_phase = cfp_pkg::PhIdle;
  logic [1:0]      prs_hdr = cfp_pkg::HdrType;
  logic [7:0]      prs_type = '0;
  logic [7:0]      prs_len = '0;
  int unsigned     prs_count = 0;
  logic [7:0]      prs_sum = '0;
  logic [7:0]      prs_start = cfp_pkg::StartByteReset;

  bit          byte_taken = 1'b0;
  bit          sender_gaps = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  pattern_pos = '0;
  int unsigned quiet_cycles = 0;

  task automatic parse_byte(input logic [7:0] b);
    cfp_pkg::result_t r;
    logic [7:0]       hdr_sum;
    logic [7:0]       cmd_offset;
    bit               frame_end;
    r = '0;
    frame_end = 1'b0;
    if (prs_phase != cfp_pkg::PhPayload && b == prs_start) begin
      prs_phase = cfp_pkg::PhHeader;
      prs_hdr = cfp_pkg::HdrType;
    end else if (prs_phase == cfp_pkg::PhHeader) begin
      case (prs_hdr)
        cfp_pkg::HdrType: begin
          prs_type = b;
          prs_hdr = cfp_pkg::HdrLength;
        end
        cfp_pkg::HdrLength: begin
          prs_len = b;
          prs_hdr = cfp_pkg::HdrSum;
        end
        default: begin
          hdr_sum = prs_start + prs_type + prs_len;
          frame_end = 1'b1;
          if (b != hdr_sum) begin
            r.status = cfp_pkg::StHdrBad;
          end else if (prs_len == 0) begin
            if (prs_type >= cfp_pkg::TypeArm && prs_type <= cfp_pkg::TypeDownload) begin
              cmd_offset = prs_type - cfp_pkg::TypeArm;
              r.status = cfp_pkg::StOk;
              r.command = cfp_pkg::command_e'(cmd_offset[1:0]);
            end else begin
              r.status = cfp_pkg::StUnknown;
            end
          end else if (prs_len > MaxPayload) begin
            r.status = cfp_pkg::StTooLong;
          end else begin
            frame_end = 1'b0;
            prs_phase = cfp_pkg::PhPayload;
            prs_hdr = cfp_pkg::HdrType;
            prs_count = 0;
            prs_sum = '0;
          end
        end
      endcase
    end else if (prs_phase == cfp_pkg::PhPayload) begin
      if (prs_count < prs_len) begin
        prs_sum = prs_sum + b;
        prs_count++;
      end else begin
        frame_end = 1'b1;
        if (b != prs_sum) begin
          r.status = cfp_pkg::StPayBad;
        end else if (prs_type == cfp_pkg::TypeArm) begin
          r.status = cfp_pkg::StOk;
          r.command = cfp_pkg::CmdArm;
        end else if (prs_type == cfp_pkg::TypeRecStart) begin
          r.status = cfp_pkg::StOk;
          r.command = cfp_pkg::CmdRecStart;
        end else begin
          r.status = cfp_pkg::StIgnored;
        end
      end
    end
    if (frame_end) begin
      r.frame_type = prs_type;
      r.payload_length = prs_len;
      prs_phase = cfp_pkg::PhIdle;
      prs_hdr = cfp_pkg::HdrType;
      expected_results.push_back(r);
    end
  endtask

  // Input side: a transfer is taken at the rising edge and predicted at once.
  always @(posedge clk_i) begin
    byte_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (byte_taken) parse_byte(s_axis_tdata_i);
  end

  always @(negedge clk_i) begin
    if (byte_taken) void'(pending_bytes.pop_front());
    if (s_axis_tvalid_i && !byte_taken) begin
      // Hold the byte until it is taken.
    end else if (gap_left != 0) begin
      s_axis_tvalid_i <= 1'b0;
      gap_left--;
    end else if (pending_bytes.size() != 0) begin
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i <= pending_bytes[0];
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = sender_gaps ? $urandom_range(1, 5) : 0;
      end else begin
        burst_left--;
      end
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ready_pattern[pattern_pos];
    pattern_pos <= pattern_pos + 1'b1;
  end

  always @(posedge clk_i) begin : result_check
    cfp_pkg::result_t got;
    cfp_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[cfp_pkg::ResultWidth-1:0];
      if (m_axis_tdata_o[cfp_pkg::TdataWidth-1:cfp_pkg::ResultWidth] != '0) begin
        $error("padding: expected 0, got %0h",
               m_axis_tdata_o[cfp_pkg::TdataWidth-1:cfp_pkg::ResultWidth]);
        fail_count++;
      end
      if (expected_results.size() == 0) begin
        $error("result with none pending: status %0d type %0h", got.status, got.frame_type);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.command != want.command) begin
          $error("command: expected %0d, got %0d", want.command, got.command);
          fail_count++;
        end
        if (got.frame_type != want.frame_type) begin
          $error("frame_type: expected %0h, got %0h", want.frame_type, got.frame_type);
          fail_count++;
        end
        if (got.payload_length != want.payload_length) begin
          $error("payload_length: expected %0d, got %0d", want.payload_length,
                 got.payload_length);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (byte_taken || cfg_we_i || (rst_ni && m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endfunction

  task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] flen,
                             input bit hdr_ok, input bit sum_ok);
    logic [7:0] hdr_sum;
    logic [7:0] pay_sum;
    logic [7:0] b;
    hdr_sum = stim_start + ftype + flen;
    pay_sum = '0;
    queue_byte(stim_start);
    queue_byte(ftype);
    queue_byte(flen);
    queue_byte(hdr_ok ? hdr_sum : hdr_sum ^ 8'($urandom_range(1, 255)));
    if (hdr_ok && flen != 0 && flen <= MaxPayload) begin
      repeat (flen) begin
        b = 8'($urandom);
        pay_sum = pay_sum + b;
        queue_byte(b);
      end
      queue_byte(sum_ok ? pay_sum : pay_sum ^ 8'($urandom_range(1, 255)));
    end
  endtask

  // Mostly whole frames with random content, the rest cut-short headers,
  // line noise and repeated sync bytes.
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned target;
    int unsigned pick;
    int unsigned len_pick;
    logic [7:0]  ftype;
    logic [7:0]  flen;
    target = bytes_queued + n_bytes;
    while (bytes_queued < target) begin
      pick = $urandom_range(0, 99);
      ftype = ($urandom_range(0, 9) < 6) ?
              8'(cfp_pkg::TypeArm + $urandom_range(0, 3)) : 8'($urandom);
      len_pick = $urandom_range(0, 9);
      if (len_pick < 4) flen = '0;
      else if (len_pick < 9) flen = 8'($urandom_range(1, MaxPayload));
      else flen = 8'($urandom);
      if (pick < 70) begin
        queue_frame(ftype, flen, $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
      end else if (pick < 80) begin
        queue_byte(stim_start);
        repeat ($urandom_range(1, 2)) queue_byte(8'($urandom));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end else begin
        queue_byte(stim_start);
        queue_frame(ftype, flen, 1'b1, 1'b1);
      end
    end
  endtask

  // Bytes that end no frame leave no trace, so keep the clock running past the
  // last result for them to pass through the pipeline.
  task automatic settle();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_start_byte(input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    stim_start = value;
    prs_start = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] start_value;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Every command, a stray byte, an unknown type, a bad header sum, an oversized
    // length and a short good payload, all under the reset sync byte.
    queue_frame(cfp_pkg::TypeArm, 8'd0, 1'b1, 1'b1);
    queue_frame(cfp_pkg::TypeRecStart, 8'd0, 1'b1, 1'b1);
    queue_frame(cfp_pkg::TypeRecStop, 8'd0, 1'b1, 1'b1);
    queue_frame(cfp_pkg::TypeDownload, 8'd0, 1'b1, 1'b1);
    queue_byte(8'h00);
    queue_frame(8'hFF, 8'd0, 1'b1, 1'b1);
    queue_frame(cfp_pkg::TypeArm, 8'd0, 1'b0, 1'b1);
    queue_frame(cfp_pkg::TypeRecStart, 8'(MaxPayload + 1), 1'b1, 1'b1);
    queue_frame(cfp_pkg::TypeArm, 8'd1, 1'b1, 1'b1);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: start_value = 8'h00;
        1: start_value = 8'hFF;
        4: start_value = cfp_pkg::StartByteReset;
        default: start_value = 8'($urandom);
      endcase
      write_start_byte(start_value);
      sender_gaps = (p % 3) != 0;
      case (p % 3)
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'($urandom) | 16'h0001;
        default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
      endcase
      random_traffic(285);
      settle();
    end

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> command_frame_parser.f
rtl/cfp_pkg.sv
rtl/cfp_parser.sv
rtl/cfp_out_fifo.sv
rtl/command_frame_parser.sv
tb/tb_top.sv
